// File: rtl/rlsd_pkg.sv
package rlsd_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SWITCHES_DEF = 6;
	localparam int ADC_BITS_DEF = 12;

	// Width of the switch count field
	localparam int COUNT_BITS = 3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch a new request, clear the best candidate
		logic load;     // start the division for the current code
		logic step;     // one quotient bit
		logic update;   // compare the finished level against the best so far
		logic advance;  // move on to the next code
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic n_ok;       // switch count lies in 1..MAX_SWITCHES
		logic div_last;   // this step yields the final quotient bit
		logic cand_last;  // current code is the highest one for this count
	} status_t;

endpackage

// File: rtl/rlsd_div.sv
module rlsd_div #(
	parameter int NW = 20,
	parameter int DW = 8,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          step,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          last
);
	import rlsd_pkg::*;

	localparam int CW = (QW > 1) ? $clog2(QW) : 1;

	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          fits;

	// Restoring division, one quotient bit per step, most significant first.
	// The caller guarantees the quotient fits in QW bits.
	assign fits = (rem_q >= dsh_q);
	assign last = (cnt_q == CW'(QW - 1));
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

endmodule

// File: rtl/rlsd_dp.sv
module rlsd_dp #(
	parameter int MAX_SWITCHES = rlsd_pkg::MAX_SWITCHES_DEF,
	parameter int ADC_BITS = rlsd_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlsd_pkg::cmd_t                  cmd,
	output rlsd_pkg::status_t               status,
	input  logic [ADC_BITS-1:0]             adc_level,
	input  logic [rlsd_pkg::COUNT_BITS-1:0] switch_count,
	output logic [MAX_SWITCHES-1:0]         switch_value
);
	import rlsd_pkg::*;

	localparam int VW = MAX_SWITCHES;
	localparam int DVW = VW + 1;          // v + 2^(n-1)
	localparam int DENW = VW + 2;         // 2*d
	localparam int NW = ADC_BITS + VW + 2;
	localparam logic [NW-1:0] FS = NW'((64'd1 << ADC_BITS) - 64'd1);

	logic [ADC_BITS-1:0]   level_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [VW-1:0]         v_q;
	logic [VW-1:0]         best_q;
	logic [ADC_BITS:0]     best_diff_q;

	logic [DVW-1:0]        half;
	logic [DVW-1:0]        d;
	logic [DVW-1:0]        v_next;
	logic [NW-1:0]         prod;
	logic [NW-1:0]         num;
	logic [DENW-1:0]       den;
	logic [ADC_BITS-1:0]   quo;
	logic [ADC_BITS:0]     diff;
	logic                  div_last;

	assign half = DVW'(1) << (n_q - COUNT_BITS'(1));
	assign d = {1'b0, v_q} + half;
	assign prod = FS * NW'(v_q);
	assign num = (prod << 1) + NW'(d);
	assign den = {d, 1'b0};
	assign v_next = {1'b0, v_q} + DVW'(1);

	rlsd_div #(
		.NW(NW),
		.DW(DENW),
		.QW(ADC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.load(cmd.load),
		.step(cmd.step),
		.num(num),
		.den(den),
		.quo(quo),
		.last(div_last)
	);

	assign diff = (level_q > quo) ? {1'b0, level_q - quo} : {1'b0, quo - level_q};

	assign status.n_ok = (n_q != '0) && (int'(n_q) <= MAX_SWITCHES);
	assign status.div_last = div_last;
	assign status.cand_last = (v_next == (DVW'(1) << n_q));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= adc_level;
			n_q <= switch_count;
			v_q <= '0;
			best_q <= '0;
			best_diff_q <= '1;
		end else begin
			// Strict compare keeps the lowest code on a tie
			if (cmd.update && (diff < best_diff_q)) begin
				best_q <= v_q;
				best_diff_q <= diff;
			end
			if (cmd.advance) begin
				v_q <= v_next[VW-1:0];
			end
		end
	end

	assign switch_value = best_q;

endmodule

// File: rtl/rlsd_ctrl.sv
module rlsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rlsd_pkg::status_t status,
	output rlsd_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import rlsd_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_LOAD   = 3'd2;
	localparam logic [2:0] S_RUN    = 3'd3;
	localparam logic [2:0] S_UPDATE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = status.n_ok ? S_LOAD : S_DONE;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d = S_RUN;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				if (status.cand_last) begin
					state_d = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// File: rtl/resistor_ladder_switch_decoder.sv
// Resistor ladder switch decoder.
// Request channel: drive adc_level and switch_count with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with switch_value, the
// code whose expected ladder level round(FS*v/(v+2^(n-1))) is closest to
// adc_level, lowest code on a tie. Counts outside 1..MAX_SWITCHES give 0.
// Each code 0..2^n-1 in turn is loaded into the shared restoring divider,
// divided over ADC_BITS quotient bits and then compared with the best so far.
// After the request the controller checks the count, walks the codes and
// then shows done; an out-of-range count goes straight from the check to done.
// busy stays high through the done cycle and falls at the edge that ends it,
// so the next request can be taken, at the earliest, in the idle cycle that follows.
// Reset: arst_n low returns the controller to idle at once; no request in
// flight survives. The receiver cannot stall: the result is shown once.
module resistor_ladder_switch_decoder #(
	parameter int MAX_SWITCHES = rlsd_pkg::MAX_SWITCHES_DEF,
	parameter int ADC_BITS = rlsd_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ADC_BITS-1:0]             adc_level,
	input  logic [rlsd_pkg::COUNT_BITS-1:0] switch_count,
	output logic                            done,
	output logic [MAX_SWITCHES-1:0]         switch_value
);
	import rlsd_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence capture, per-code divide and compare, then strobe the result
	rlsd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	// Hold the request, walk the codes, keep the closest one
	rlsd_dp #(
		.MAX_SWITCHES(MAX_SWITCHES),
		.ADC_BITS(ADC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.adc_level(adc_level),
		.switch_count(switch_count),
		.switch_value(switch_value)
	);

endmodule

// File: dv/ladder_decode_checker.sv
module ladder_decode_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [rlsd_pkg::ADC_BITS_DEF-1:0]     adc_level,
	input  logic [rlsd_pkg::COUNT_BITS-1:0]       switch_count,
	input  logic                                  done,
	input  logic [rlsd_pkg::MAX_SWITCHES_DEF-1:0] switch_value,
	output int                                    fail_count,
	output int                                    open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_SCALE = (1 << rlsd_pkg::ADC_BITS_DEF) - 1;

	logic [rlsd_pkg::MAX_SWITCHES_DEF-1:0] expected_codes[$];

	// Try every code and keep the one whose ladder level sits closest;
	// a strict compare keeps the lowest code on equal distance.
	function automatic logic [rlsd_pkg::MAX_SWITCHES_DEF-1:0] nearest_ladder_code(
		input logic [rlsd_pkg::ADC_BITS_DEF-1:0] level,
		input logic [rlsd_pkg::COUNT_BITS-1:0]   count
	);
		longint unsigned divisor;
		longint unsigned ladder;
		longint unsigned gap;
		longint unsigned best_gap;
		int              best_code;

		best_gap  = 64'hFFFF_FFFF_FFFF_FFFF;
		best_code = 0;
		if (count == 0 || count > rlsd_pkg::MAX_SWITCHES_DEF)
			return '0;
		for (int code = 0; code < (1 << count); code++) begin
			divisor = 64'(code) + (64'd1 << (count - 3'd1));
			ladder  = (64'(2 * FULL_SCALE * code) + divisor) / (64'd2 * divisor);
			gap     = (64'(level) > ladder) ? (64'(level) - ladder)
				: (ladder - 64'(level));
			if (gap < best_gap) begin
				best_gap  = gap;
				best_code = code;
			end
		end
		return best_code[rlsd_pkg::MAX_SWITCHES_DEF-1:0];
	endfunction

	initial begin
		fail_count = 0;
		open_count = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_codes.push_back(nearest_ladder_code(adc_level, switch_count));
			if (done) begin
				if (expected_codes.size() == 0) begin
					$display("%0t: switch_value expected none actual %0d", $time,
						switch_value);
					fail_count = fail_count + 1;
				end else begin
					if (switch_value !== expected_codes[0]) begin
						$display("%0t: switch_value expected %0d actual %0d", $time,
							expected_codes[0], switch_value);
						fail_count = fail_count + 1;
					end
					void'(expected_codes.pop_front());
				end
			end
			open_count <= expected_codes.size();
		end
	end

endmodule

// File: dv/resistor_ladder_switch_decoder_tb.sv
module resistor_ladder_switch_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LVL_BITS  = rlsd_pkg::ADC_BITS_DEF;
	localparam int CNT_BITS  = rlsd_pkg::COUNT_BITS;
	localparam int CODE_BITS = rlsd_pkg::MAX_SWITCHES_DEF;
	localparam int LVL_MAX   = (1 << LVL_BITS) - 1;
	// Time for one six-switch request, the slowest kind.
	localparam int SLOWEST_REQUEST = 900;
	localparam int QUIET_LIMIT     = 10000;
	localparam int RANDOM_REQUESTS = 420;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [LVL_BITS-1:0]  adc_level;
	logic [CNT_BITS-1:0]  switch_count;
	logic                 done;
	logic [CODE_BITS-1:0] switch_value;
	int                   fail_count;
	int                   open_count;
	int                   quiet_cycles;
	bit                   calm_stretch;

	resistor_ladder_switch_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.adc_level   (adc_level),
		.switch_count(switch_count),
		.done        (done),
		.switch_value(switch_value)
	);

	ladder_decode_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.adc_level   (adc_level),
		.switch_count(switch_count),
		.done        (done),
		.switch_value(switch_value),
		.fail_count  (fail_count),
		.open_count  (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: count cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Present one request and hold it until the block takes it. Returns in
	// the time step of the accepting edge, so start is still high there.
	task automatic send_request(input logic [LVL_BITS-1:0] lvl,
		input logic [CNT_BITS-1:0] cnt);
		adc_level    <= lvl;
		switch_count <= cnt;
		start        <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Outside the calm stretch, now and then drop start for a random gap. Most
	// gaps are short and land inside the busy window; some run long enough to
	// spill past the done cycle so the block also sits idle waiting for us.
	task automatic sender_gap();
		int gap_len;
		if (calm_stretch || $urandom_range(0, 99) >= 21)
			return;
		gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1200)
			: $urandom_range(1, 8);
		start <= 1'b0;
		repeat (gap_len)
			@(posedge clk);
	endtask

	task automatic send_and_pause(input logic [LVL_BITS-1:0] lvl,
		input logic [CNT_BITS-1:0] cnt);
		send_request(lvl, cnt);
		sender_gap();
	endtask

	initial begin
		logic [LVL_BITS-1:0] lvl;
		logic [CNT_BITS-1:0] cnt;

		arst_n       = 1'b0;
		start        = 1'b0;
		adc_level    = '0;
		switch_count = '0;
		quiet_cycles = 0;
		calm_stretch = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Counts outside the ladder range answer zero without walking any code.
		send_and_pause(12'd0, 3'd0);
		send_and_pause(LVL_BITS'(LVL_MAX), 3'd0);
		send_and_pause(LVL_BITS'(LVL_MAX), 3'd7);
		send_and_pause(12'd2048, 3'd7);
		// Both rails for every legal count.
		for (int n = 1; n <= CODE_BITS; n++) begin
			send_and_pause(12'd0, n[CNT_BITS-1:0]);
			send_and_pause(LVL_BITS'(LVL_MAX), n[CNT_BITS-1:0]);
		end
		// One switch: halfway between the two levels ties, lowest code wins.
		send_and_pause(12'd1024, 3'd1);
		send_and_pause(12'd1025, 3'd1);
		// Levels that hit a ladder step exactly.
		send_and_pause(12'd1365, 3'd2);
		send_and_pause(12'd2048, 3'd6);
		// Alternating bit patterns.
		send_and_pause(12'hAAA, 3'd6);
		send_and_pause(12'h555, 3'd5);

		// Random part: mostly uniform levels, with extra weight near the rails.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			calm_stretch = (i >= 150 && i < 250);
			case ($urandom_range(0, 19))
				0, 1, 2: lvl = LVL_BITS'($urandom_range(0, 63));
				3, 4, 5: lvl = LVL_BITS'($urandom_range(LVL_MAX - 63, LVL_MAX));
				default: lvl = LVL_BITS'($urandom_range(0, LVL_MAX));
			endcase
			cnt = CNT_BITS'($urandom_range(0, (1 << CNT_BITS) - 1));
			send_and_pause(lvl, cnt);
		end

		// Drain: let the last push settle, wait for every result, then give a
		// stray done the time of one slow request to show up.
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (SLOWEST_REQUEST + 10)
			@(posedge clk);

		if (fail_count == 0 && open_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: resistor_ladder_switch_decoder.f
rtl/rlsd_pkg.sv
rtl/rlsd_div.sv
rtl/rlsd_dp.sv
rtl/rlsd_ctrl.sv
rtl/resistor_ladder_switch_decoder.sv
dv/ladder_decode_checker.sv
dv/resistor_ladder_switch_decoder_tb.sv
